/* rtl/sha1_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types and constants of the SHA-1 hash core.
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam int unsigned ROUNDS = 80;
  localparam int unsigned BLOCK_BITS = 512;
  localparam int unsigned DIGEST_WORDS = 5;

  // controller -> datapath
  typedef struct packed {
    logic       put;       // write a byte into the block window
    logic [1:0] put_sel;   // which byte source
    logic       add_len;   // count a message byte
    logic       comp_init; // load work regs from chain
    logic       round;     // one round
    logic       comp_fin;  // add work regs into chain
    logic       msg_reset; // reset chain, length, byte pos
  } sha1_cmd_t;

  localparam logic [1:0] SEL_DATA = 2'd0;
  localparam logic [1:0] SEL_PAD  = 2'd1;
  localparam logic [1:0] SEL_ZERO = 2'd2;
  localparam logic [1:0] SEL_LEN  = 2'd3;

  // datapath -> controller
  typedef struct packed {
    logic [5:0] byte_pos;
    logic       last_round;
  } sha1_stat_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

endpackage
`default_nettype wire

/* rtl/sha1_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_in_if / sha1_out_if
// Valid/ready channels of the SHA-1 hash core.
// ----------------------------------------------------------------------------
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last;
  modport source (output valid, data_byte, byte_valid, last, input ready);
  modport sink (input valid, data_byte, byte_valid, last, output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

/* rtl/sha1_hash_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_hash_core
// Streaming SHA-1 over a byte stream; five digest words per message.
// ----------------------------------------------------------------------------
// channel | dir | payload
// in_*    | in  | data_byte[7:0], byte_valid, last
// out_*   | out | digest_word[31:0], word_index[2:0], last_word
//
// A filled 64-byte block runs 80 rounds on the single round unit; the chain
// add comes in the cycle after the last round. On last, padding writes its
// bytes in turn, pausing while a block compresses, and the five words leave
// one per accepted out item, starting the cycle after the final chain add.
// Synchronous active-low reset returns to the SHA-1 initial values.
// in_ready is low while a block compresses, pads or the digest drains.
// ----------------------------------------------------------------------------
module sha1_hash_core
  import sha1_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sha1_in_if.sink    in_ch,
  sha1_out_if.source out_ch
);

  sha1_cmd_t  cmd;
  sha1_stat_t stat;
  logic [2:0] widx;
  logic       ovalid;
  logic       in_rdy;

  sha1_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_byte_valid (in_ch.byte_valid),
    .in_last       (in_ch.last),
    .in_ready      (in_rdy),
    .out_valid     (ovalid),
    .out_ready     (out_ch.ready),
    .word_idx      (widx),
    .stat          (stat),
    .cmd           (cmd)
  );

  sha1_datapath #(.LENGTH_BITS(LENGTH_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .data_byte (in_ch.data_byte),
    .rd_index  (widx),
    .stat      (stat),
    .rd_word   (out_ch.digest_word)
  );

  assign in_ch.ready       = in_rdy;
  assign out_ch.valid      = ovalid;
  assign out_ch.word_index = widx;
  assign out_ch.last_word  = (widx == 3'(DIGEST_WORDS - 1));

endmodule
`default_nettype wire

/* rtl/sha1_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_datapath
// Block window, round registers, chaining hash and length counter.
// ----------------------------------------------------------------------------
module sha1_datapath
  import sha1_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire sha1_cmd_t   cmd,
  input  wire logic [7:0]  data_byte,
  input  wire logic [2:0]  rd_index,
  output sha1_stat_t       stat,
  output logic [31:0]      rd_word
);

  logic [31:0]            win_r [16];
  logic [31:0]            h_r [5];
  logic [31:0]            w_r [5];
  logic [LENGTH_BITS-1:0] len_r;
  logic [LENGTH_BITS-1:0] len_snap_r;
  logic [5:0]             pos_r;
  logic [2:0]             len_idx_r;
  logic [6:0]             rnd_r;
  logic [63:0]            len64;
  logic [7:0]             put_byte;
  logic [31:0]            w_new, w_sel, f, k, tmp;
  logic [3:0]             t4;

  assign len64 = 64'(len_snap_r);

  always_comb begin
    case (cmd.put_sel)
      SEL_DATA: put_byte = data_byte;
      SEL_PAD:  put_byte = 8'h80;
      SEL_ZERO: put_byte = 8'h00;
      default:  put_byte = len64[8*(7-len_idx_r) +: 8];
    endcase
  end

  assign t4 = rnd_r[3:0];
  assign w_new = rotl(win_r[t4 + 4'd13] ^ win_r[t4 + 4'd8] ^ win_r[t4 + 4'd2] ^ win_r[t4], 1);
  assign w_sel = (rnd_r < 7'd16) ? win_r[t4] : w_new;

  always_comb begin
    if (rnd_r < 7'd20) begin
      f = (w_r[1] & w_r[2]) | (~w_r[1] & w_r[3]);
      k = K0;
    end else if (rnd_r < 7'd40) begin
      f = w_r[1] ^ w_r[2] ^ w_r[3];
      k = K1;
    end else if (rnd_r < 7'd60) begin
      f = (w_r[1] & w_r[2]) | (w_r[1] & w_r[3]) | (w_r[2] & w_r[3]);
      k = K2;
    end else begin
      f = w_r[1] ^ w_r[2] ^ w_r[3];
      k = K3;
    end
  end
  assign tmp = rotl(w_r[0], 5) + f + w_r[4] + w_sel + k;

  // window: byte packing and schedule writeback
  always_ff @(posedge clk) begin
    if (cmd.put) begin
      if (pos_r[1:0] == 2'd0) begin
        win_r[pos_r[5:2]] <= {put_byte, 24'h0};
      end else begin
        win_r[pos_r[5:2]][8*(3-pos_r[1:0]) +: 8] <= put_byte;
      end
    end else if (cmd.round && rnd_r >= 7'd16) begin
      win_r[t4] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r[0] <= H0_INIT; h_r[1] <= H1_INIT; h_r[2] <= H2_INIT;
      h_r[3] <= H3_INIT; h_r[4] <= H4_INIT;
      len_r <= '0;
      pos_r <= '0;
      rnd_r <= '0;
      len_idx_r <= '0;
      for (int i = 0; i < 5; i++) w_r[i] <= '0;
    end else begin
      if (cmd.put) begin
        pos_r <= pos_r + 6'd1;
        if (cmd.put_sel == SEL_LEN) len_idx_r <= len_idx_r + 3'd1;
        if (cmd.put_sel == SEL_PAD) begin
          len_snap_r <= len_r;
          len_idx_r <= '0;
        end
      end
      if (cmd.add_len) len_r <= len_r + LENGTH_BITS'(8);
      if (cmd.comp_init) begin
        for (int i = 0; i < 5; i++) w_r[i] <= h_r[i];
        rnd_r <= '0;
      end
      if (cmd.round) begin
        w_r[0] <= tmp;
        w_r[1] <= w_r[0];
        w_r[2] <= rotl(w_r[1], 30);
        w_r[3] <= w_r[2];
        w_r[4] <= w_r[3];
        rnd_r <= (rnd_r == 7'(ROUNDS - 1)) ? 7'd0 : rnd_r + 7'd1;
      end
      if (cmd.comp_fin) begin
        for (int i = 0; i < 5; i++) h_r[i] <= h_r[i] + w_r[i];
      end
      if (cmd.msg_reset) begin
        h_r[0] <= H0_INIT; h_r[1] <= H1_INIT; h_r[2] <= H2_INIT;
        h_r[3] <= H3_INIT; h_r[4] <= H4_INIT;
        len_r <= '0;
        pos_r <= '0;
      end
    end
  end

  assign stat.byte_pos = pos_r;
  assign stat.last_round = (rnd_r == 7'(ROUNDS - 1));
  assign rd_word = h_r[(rd_index > 3'd4) ? 3'd4 : rd_index];

endmodule
`default_nettype wire

/* rtl/sha1_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_ctrl
// Sequencer: byte intake, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module sha1_ctrl
  import sha1_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_byte_valid,
  input  wire logic       in_last,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      word_idx,
  input  wire sha1_stat_t stat,
  output sha1_cmd_t       cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PAD   = 6'b000010,
    S_ZERO  = 6'b000100,
    S_LEN   = 6'b001000,
    S_ROUND = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  state_t     ret_r, ret_nxt;   // where to resume after a compression
  logic [2:0] widx_r, widx_nxt;
  logic       fin_r, fin_nxt;   // compression was the last one of the message
  logic       fin_pend_r;       // chain update happens the cycle after the last round
  sha1_cmd_t  cmd_c;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    widx_nxt  = widx_r;
    fin_nxt   = fin_r;
    cmd_c     = '0;
    in_ready  = (state_r == S_IDLE);
    out_valid = (state_r == S_OUT) && !fin_pend_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_c.put_sel = SEL_DATA;
          if (in_byte_valid) begin
            cmd_c.put = 1'b1;
            cmd_c.add_len = 1'b1;
          end
          if (in_byte_valid && stat.byte_pos == 6'd63) begin
            cmd_c.comp_init = 1'b1;
            state_nxt = S_ROUND;
            ret_nxt = in_last ? S_PAD : S_IDLE;
          end else if (in_last) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd_c.put = 1'b1;
        cmd_c.put_sel = SEL_PAD;
        if (stat.byte_pos == 6'd63) begin
          cmd_c.comp_init = 1'b1;
          state_nxt = S_ROUND;
          ret_nxt = S_ZERO;
        end else if (stat.byte_pos == 6'd55) begin
          state_nxt = S_LEN;
        end else begin
          state_nxt = S_ZERO;
        end
      end
      S_ZERO: begin
        if (stat.byte_pos == 6'd56) begin
          state_nxt = S_LEN;
        end else begin
          cmd_c.put = 1'b1;
          cmd_c.put_sel = SEL_ZERO;
          if (stat.byte_pos == 6'd63) begin
            cmd_c.comp_init = 1'b1;
            state_nxt = S_ROUND;
            ret_nxt = S_ZERO;
          end
        end
      end
      S_LEN: begin
        cmd_c.put = 1'b1;
        cmd_c.put_sel = SEL_LEN;
        if (stat.byte_pos == 6'd63) begin
          cmd_c.comp_init = 1'b1;
          state_nxt = S_ROUND;
          ret_nxt = S_OUT;
          fin_nxt = 1'b1;
        end
      end
      S_ROUND: begin
        cmd_c.round = 1'b1;
        if (stat.last_round) begin
          state_nxt = ret_r;
          widx_nxt = '0;
        end
      end
      S_OUT: begin
        if (out_ready && !fin_pend_r) begin
          widx_nxt = widx_r + 3'd1;
          if (widx_r == 3'(DIGEST_WORDS - 1)) begin
            cmd_c.msg_reset = 1'b1;
            fin_nxt = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r <= S_IDLE;
      widx_r <= '0;
      fin_r <= 1'b0;
      fin_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      widx_r <= widx_nxt;
      fin_r <= fin_nxt;
      fin_pend_r <= (state_r == S_ROUND) && stat.last_round;
    end
  end

  // comp_fin is driven in the cycle after the last round; no other command
  // touches the chain or work regs in that cycle, and output is held off in it.
  always_comb begin
    cmd = cmd_c;
    cmd.comp_fin = fin_pend_r;
  end

  assign word_idx = widx_r;

  property p_out_only_final;
    @(posedge clk) disable iff (!rst_n) out_valid |-> fin_r;
  endproperty
  a_out_only_final: assert property (p_out_only_final) else $error("digest without final block");

  property p_idx_range;
    @(posedge clk) disable iff (!rst_n) out_valid |-> (widx_r <= 3'd4);
  endproperty
  a_idx_range: assert property (p_idx_range) else $error("word index out of range");

  property p_no_accept_busy;
    @(posedge clk) disable iff (!rst_n) (state_r != S_IDLE) |-> !in_ready;
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

endmodule
`default_nettype wire

/* dv/tb_sha1_hash_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha1_hash_core
// Self-checking bench for the streaming SHA-1 core. Messages are fed at most one
// byte per item under several sender/receiver stall mixes, and every digest
// word is checked against a behavioral SHA-1 kept in the bench.
// ----------------------------------------------------------------------------
module tb_sha1_hash_core;
  import sha1_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned TAIL_CYCLES = 400;
  localparam int unsigned RAND_ITEMS  = 210;
  localparam int unsigned MIN_WORDS   = 40;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        lastw;
  } digest_word_t;

  logic clk;
  logic rst_n;

  sha1_in_if  in_ch ();
  sha1_out_if out_ch ();

  sha1_hash_core DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // bench copy of the hash state
  logic [31:0] chain_h [5];
  logic [31:0] sched_w [16];
  logic [63:0] msg_bits;
  logic [5:0]  blk_pos;

  digest_word_t digest_q[$];
  int unsigned  mismatches;
  int unsigned  words_seen;
  int unsigned  items_sent;
  int unsigned  cycles;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [31:0] rol(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void hash_reset();
    chain_h[0] = H0_INIT;
    chain_h[1] = H1_INIT;
    chain_h[2] = H2_INIT;
    chain_h[3] = H3_INIT;
    chain_h[4] = H4_INIT;
    msg_bits = '0;
    blk_pos  = '0;
  endfunction

  function automatic void compress_blk();
    logic [31:0] a, b, c, d, e, w, f, k, t;
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        w = sched_w[r];
      end else begin
        w = rol(sched_w[(r + 13) & 15] ^ sched_w[(r + 8) & 15] ^
                sched_w[(r + 2) & 15] ^ sched_w[r & 15], 1);
        sched_w[r & 15] = w;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d); k = K0;
      end else if (r < 40) begin
        f = b ^ c ^ d; k = K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d); k = K2;
      end else begin
        f = b ^ c ^ d; k = K3;
      end
      t = rol(a, 5) + f + e + w + k;
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d; chain_h[4] += e;
  endfunction

  function automatic void absorb_byte(input logic [7:0] bt);
    int unsigned sh;
    sh = (3 - blk_pos[1:0]) * 8;
    if (blk_pos[1:0] == 2'd0) sched_w[blk_pos[5:2]] = 32'(bt) << sh;
    else sched_w[blk_pos[5:2]] |= 32'(bt) << sh;
    blk_pos = blk_pos + 6'd1;
    if (blk_pos == 6'd0) compress_blk();
  endfunction

  // pad, append length, queue the five digest words
  function automatic void finish_digest();
    logic [63:0] len;
    digest_word_t dw;
    len = msg_bits;
    absorb_byte(8'h80);
    while (blk_pos != 6'd56) absorb_byte(8'h00);
    for (int i = 7; i >= 0; i--) absorb_byte(len[i*8 +: 8]);
    for (int i = 0; i < 5; i++) begin
      dw.word  = chain_h[i];
      dw.idx   = 3'(i);
      dw.lastw = (i == 4);
      digest_q.push_back(dw);
    end
    hash_reset();
  endfunction

  function automatic void predict_item(input logic [7:0] bt, input logic bv, input logic lst);
    if (bv) begin
      absorb_byte(bt);
      msg_bits = msg_bits + 64'd8;
    end
    if (lst) finish_digest();
  endfunction

  // valid stays up between back-to-back items; lowered only for a gap
  task automatic send_item(input logic [7:0] bt, input logic bv, input logic lst);
    logic rdy;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= bt;
    in_ch.byte_valid <= bv;
    in_ch.last       <= lst;
    forever begin
      @(negedge clk);
      rdy = in_ch.ready;
      @(posedge clk);
      if (rdy) break;
    end
    items_sent++;
    predict_item(bt, bv, lst);
  endtask

  task automatic send_random_msg();
    int unsigned len;
    len = ($urandom_range(9) < 2) ? $urandom_range(70, 50) : $urandom_range(12);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      if (i == len - 1 && $urandom_range(3) != 0) send_item(8'($urandom), 1'b1, 1'b1);
      else send_item(8'($urandom), 1'b1, 1'b0);
    end
    if (len == 0 || blk_pos != 6'd0 || msg_bits != 64'd0)
      send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic test_directed();
    send_idle_pct = 0; recv_stall_pct = 0;
    send_item(8'h00, 1'b0, 1'b1);                 // empty message
    send_item(8'h61, 1'b1, 1'b0);                 // "abc" with an ignored item inside
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);                 // ended by an item with no byte
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);                 // single zero byte
    send_item(8'hFF, 1'b1, 1'b1);
  endtask

  task automatic test_block_edges();
    // 55 bytes fits one padded block, 56 forces a second
    for (int n = 55; n <= 56; n++)
      for (int i = 0; i < n; i++) send_item(8'($urandom), 1'b1, i == n - 1);
  endtask

  task automatic test_stall_mix();
    int unsigned phase;
    phase = 0;
    while (phase < 4 || items_sent < RAND_ITEMS ||
           words_seen + digest_q.size() < MIN_WORDS) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      send_random_msg();
      phase++;
    end
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 30; recv_stall_pct = 30;
    send_random_msg();
    in_ch.valid <= 1'b0;
    wait (digest_q.size() == 0);
    @(posedge clk);
    send_random_msg();
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // sample at the falling edge, item moves at the next rising edge
  always @(negedge clk) begin
    digest_word_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.word  = out_ch.digest_word;
      got.idx   = out_ch.word_index;
      got.lastw = out_ch.last_word;
      words_seen++;
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest item %h/%0d/%b",
                                       got.word, got.idx, got.lastw);
      end else begin
        want = digest_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: exp %h idx %0d last %b, got %h idx %0d last %b",
                     want.word, want.idx, want.lastw, got.word, got.idx, got.lastw);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    cycles = 0; mismatches = 0; words_seen = 0; items_sent = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.data_byte = '0; in_ch.byte_valid = 1'b0; in_ch.last = 1'b0;
    for (int i = 0; i < 16; i++) sched_w[i] = '0;
    hash_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_block_edges();
    test_drain_pause();
    test_stall_mix();

    in_ch.valid <= 1'b0;
    wait (digest_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sha1_hash_core.f */
rtl/sha1_pkg.sv
rtl/sha1_if.sv
rtl/sha1_datapath.sv
rtl/sha1_ctrl.sv
rtl/sha1_hash_core.sv
dv/tb_sha1_hash_core.sv
